[rtl/pwl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the three-point piecewise linear map.
// No dependencies; every other file imports this package.
package pwl_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int DIFF_W        = VALUE_WIDTH + 1;
	localparam int PROD_W        = 2 * DIFF_W;
	localparam int SUM_W         = DIFF_W + 2;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int REG_IDX_W     = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	localparam reg_idx_t REG_START_X = reg_idx_t'(0);
	localparam reg_idx_t REG_START_Y = reg_idx_t'(1);
	localparam reg_idx_t REG_KNEE_X  = reg_idx_t'(2);
	localparam reg_idx_t REG_KNEE_Y  = reg_idx_t'(3);
	localparam reg_idx_t REG_END_X   = reg_idx_t'(4);
	localparam reg_idx_t REG_END_Y   = reg_idx_t'(5);

	localparam value_t FIX_ONE     = value_t'(1) << FRACTION_BITS;
	localparam value_t FIX_NEG_ONE = -FIX_ONE;
	localparam value_t FIX_ZERO    = '0;
	localparam value_t VALUE_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t VALUE_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	// One classified segment: offset, rise, run, base value and zero-width flag
	typedef struct packed {
		diff_t  num;
		diff_t  mul;
		diff_t  den;
		value_t base;
		logic   zero;
	} seg_t;

endpackage

[rtl/pwl_front.sv]
`timescale 1ns / 1ps
// Front end: breakpoint registers, input clamp and segment classification.
// Depends on pwl_pkg.
module pwl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pwl_pkg::value_t   sample,
	output logic              full,
	input  logic              cfg_wr_en,
	input  pwl_pkg::reg_idx_t cfg_index,
	input  pwl_pkg::value_t   cfg_data,
	output logic              seg_push,
	output pwl_pkg::seg_t     seg,
	input  logic              seg_full
);
	import pwl_pkg::*;

	value_t start_x_q, start_y_q, knee_x_q, knee_y_q, end_x_q, end_y_q;
	logic   adv;
	logic   vld_s1, vld_s2;
	value_t sample_s1, clamp_s2;
	logic   asc_s2;
	logic   asc_d;
	value_t clamp_d;
	value_t xa, ya, xb, yb;
	logic   zero_d;

	function automatic diff_t sub_ext(value_t a, value_t b);
		return {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= FIX_NEG_ONE;
			start_y_q <= FIX_NEG_ONE;
			knee_x_q  <= FIX_ZERO;
			knee_y_q  <= FIX_ZERO;
			end_x_q   <= FIX_ONE;
			end_y_q   <= FIX_ONE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_KNEE_X:  knee_x_q  <= cfg_data;
				REG_KNEE_Y:  knee_y_q  <= cfg_data;
				REG_END_X:   end_x_q   <= cfg_data;
				REG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv  = !seg_full;
	assign full = seg_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample;
			clamp_s2  <= clamp_d;
			asc_s2    <= asc_d;
		end
	end

	// clamp to the span, whichever way it runs
	assign asc_d = start_x_q < end_x_q;

	always_comb begin
		clamp_d = sample_s1;
		if (asc_d) begin
			if (sample_s1 < start_x_q)
				clamp_d = start_x_q;
			else if (sample_s1 > end_x_q)
				clamp_d = end_x_q;
		end else begin
			if (sample_s1 < end_x_q)
				clamp_d = end_x_q;
			else if (sample_s1 > start_x_q)
				clamp_d = start_x_q;
		end
	end

	// pick the segment on the sample's side of the knee
	always_comb begin
		if (asc_s2) begin
			if (clamp_s2 <= knee_x_q) begin
				xa = start_x_q;
				ya = start_y_q;
				xb = knee_x_q;
				yb = knee_y_q;
			end else begin
				xa = knee_x_q;
				ya = knee_y_q;
				xb = end_x_q;
				yb = end_y_q;
			end
		end else begin
			xa = knee_x_q;
			ya = knee_y_q;
			if (clamp_s2 >= knee_x_q) begin
				xb = start_x_q;
				yb = start_y_q;
			end else begin
				xb = end_x_q;
				yb = end_y_q;
			end
		end
	end

	assign zero_d = xb == xa;

	always_comb begin
		seg.num  = sub_ext(clamp_s2, xa);
		seg.mul  = sub_ext(yb, ya);
		seg.den  = sub_ext(xb, xa);
		seg.base = zero_d ? knee_y_q : ya;
		seg.zero = zero_d;
	end

	assign seg_push = vld_s2 && adv;

endmodule

[rtl/pwl_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified segments between the front and back ends.
// Depends on pwl_pkg.
module pwl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pwl_pkg::seg_t wdata,
	output logic          full,
	input  logic          pop,
	output pwl_pkg::seg_t rdata,
	output logic          empty
);
	import pwl_pkg::*;

	seg_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q, rptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push, do_pop;

	assign full    = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				if (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1))
					wptr_q <= '0;
				else
					wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1))
					rptr_q <= '0;
				else
					rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

[rtl/pwl_back.sv]
`timescale 1ns / 1ps
// Back end: magnitude stage, multiplier, pipelined long division, saturation
// and the result queue. Depends on pwl_pkg.
module pwl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            seg_empty,
	input  pwl_pkg::seg_t   seg,
	output logic            seg_pop,
	output logic            empty,
	input  logic            pop,
	output pwl_pkg::value_t mapped,
	output logic            zero_span
);
	import pwl_pkg::*;

	typedef struct packed {
		logic [DIFF_W-1:0] rem;
		logic [DIFF_W-1:0] lq;
		logic [DIFF_W-1:0] den;
		logic              neg;
		logic              zero;
		value_t            base;
	} dv_t;

	typedef struct packed {
		value_t mapped;
		logic   zero_span;
	} res_t;

	logic                adv;
	logic                vld_s1, vld_s2;
	logic [DIFF_W-1:0]   a_s1, b_s1, d_s1, d_s2;
	logic                neg_s1, neg_s2, zero_s1, zero_s2;
	value_t              base_s1, base_s2;
	logic [PROD_W-1:0]   prod_d, prod_s2;
	dv_t                 dv_s  [DIFF_W];
	dv_t                 dv_in [DIFF_W];
	dv_t                 dv_nx [DIFF_W];
	logic [DIFF_W:0]     trial [DIFF_W];
	logic [DIFF_W-1:0]   ge;
	logic [DIFF_W-1:0]   dv_vld_s;
	dv_t                 fin;
	logic signed [SUM_W-1:0] base_x, q_x, sum_d;
	logic                ovf;
	value_t              sat_d;
	res_t                res_d;
	res_t                oq_mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] oq_wptr_q, oq_rptr_q;
	logic [QUEUE_AW:0]   oq_cnt_q;
	logic                oq_full, oq_push, oq_pop;

	function automatic logic [DIFF_W-1:0] mag(diff_t v);
		return v[DIFF_W-1] ? -v : v;
	endfunction

	assign adv     = !oq_full;
	assign seg_pop = adv && !seg_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			dv_vld_s <= '0;
		end else if (adv) begin
			vld_s1   <= !seg_empty;
			vld_s2   <= vld_s1;
			dv_vld_s <= {dv_vld_s[DIFF_W-2:0], vld_s2};
		end
	end

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= mag(seg.num);
			b_s1    <= mag(seg.mul);
			d_s1    <= mag(seg.den);
			neg_s1  <= seg.num[DIFF_W-1] ^ seg.mul[DIFF_W-1] ^ seg.den[DIFF_W-1];
			zero_s1 <= seg.zero;
			base_s1 <= seg.base;
		end
	end

	assign prod_d = a_s1 * b_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod_d;
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			base_s2 <= base_s1;
		end
	end

	// one quotient bit per stage; the offset never exceeds the run, so the
	// upper half of the product is already below the divisor
	always_comb begin
		dv_in[0].rem  = prod_s2[PROD_W-1:DIFF_W];
		dv_in[0].lq   = prod_s2[DIFF_W-1:0];
		dv_in[0].den  = d_s2;
		dv_in[0].neg  = neg_s2;
		dv_in[0].zero = zero_s2;
		dv_in[0].base = base_s2;
		for (int k = 1; k < DIFF_W; k++)
			dv_in[k] = dv_s[k-1];
		for (int k = 0; k < DIFF_W; k++) begin
			trial[k]     = {dv_in[k].rem, dv_in[k].lq[DIFF_W-1]};
			ge[k]        = trial[k] >= {1'b0, dv_in[k].den};
			dv_nx[k]     = dv_in[k];
			dv_nx[k].rem = ge[k] ? DIFF_W'(trial[k] - {1'b0, dv_in[k].den})
			                     : trial[k][DIFF_W-1:0];
			dv_nx[k].lq  = {dv_in[k].lq[DIFF_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIFF_W; k++)
				dv_s[k] <= dv_nx[k];
		end
	end

	// apply sign, add base, saturate
	assign fin    = dv_s[DIFF_W-1];
	assign base_x = {{(SUM_W-VALUE_WIDTH){fin.base[VALUE_WIDTH-1]}}, fin.base};
	assign q_x    = {{(SUM_W-DIFF_W){1'b0}}, fin.lq};
	assign sum_d  = fin.neg ? base_x - q_x : base_x + q_x;
	assign ovf    = (|sum_d[SUM_W-1:VALUE_WIDTH-1]) && !(&sum_d[SUM_W-1:VALUE_WIDTH-1]);
	assign sat_d  = ovf ? (sum_d[SUM_W-1] ? VALUE_MIN : VALUE_MAX)
	                    : sum_d[VALUE_WIDTH-1:0];

	always_comb begin
		res_d.mapped    = fin.zero ? fin.base : sat_d;
		res_d.zero_span = fin.zero;
	end

	// result queue
	assign oq_full   = oq_cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty     = oq_cnt_q == '0;
	assign oq_push   = adv && dv_vld_s[DIFF_W-1];
	assign oq_pop    = pop && !empty;
	assign mapped    = oq_mem_q[oq_rptr_q].mapped;
	assign zero_span = oq_mem_q[oq_rptr_q].zero_span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wptr_q <= '0;
			oq_rptr_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			if (oq_push) begin
				if (oq_wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1))
					oq_wptr_q <= '0;
				else
					oq_wptr_q <= oq_wptr_q + 1'b1;
			end
			if (oq_pop) begin
				if (oq_rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1))
					oq_rptr_q <= '0;
				else
					oq_rptr_q <= oq_rptr_q + 1'b1;
			end
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_mem_q[oq_wptr_q] <= res_d;
	end

endmodule

[rtl/three_point_piecewise_linear_map.sv]
`timescale 1ns / 1ps
// Three-point piecewise linear map, top level. Depends on pwl_pkg, pwl_front,
// pwl_queue and pwl_back.
// Throughput: one item per cycle unless the result queue is full, set by the
// 33-stage long-division pipeline (one quotient bit per stage) behind a
// registered 33 x 33 multiplier.
// Reset: queues and stage valids clear; breakpoints load -1.0, 0.0, +1.0.
module three_point_piecewise_linear_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pwl_pkg::value_t   sample,
	output logic              empty,
	input  logic              pop,
	output pwl_pkg::value_t   mapped,
	output logic              zero_span,
	input  logic              cfg_wr_en,
	input  pwl_pkg::reg_idx_t cfg_index,
	input  pwl_pkg::value_t   cfg_data
);
	import pwl_pkg::*;

	seg_t seg_in, seg_out;
	logic seg_push, seg_full, seg_pop, seg_empty;

	pwl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg_push  (seg_push),
		.seg       (seg_in),
		.seg_full  (seg_full)
	);

	pwl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (seg_push),
		.wdata  (seg_in),
		.full   (seg_full),
		.pop    (seg_pop),
		.rdata  (seg_out),
		.empty  (seg_empty)
	);

	pwl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_empty (seg_empty),
		.seg       (seg_out),
		.seg_pop   (seg_pop),
		.empty     (empty),
		.pop       (pop),
		.mapped    (mapped),
		.zero_span (zero_span)
	);

	a_reset_clear: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not cleared by reset");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		seg_pop |-> !seg_empty)
		else $error("back end took a segment from an empty queue");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(seg_full && seg_empty))
		else $error("segment queue both full and empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_full && !seg_pop) |=> !$past(seg_push))
		else $error("front end pushed into a full queue");

endmodule
